// ===== rtl/core/fixed_chunk_free_list_allocator_top_defines.svh =====
// Assertion macros for the chunk allocator core.
// Needs signals clk and arst_n in the including module's scope.
`ifndef FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FCFL_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define FCFL_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/fcfl_pkg.sv =====
// Shared widths, codes and controller/datapath command types for the chunk allocator.
// No dependencies.
package fcfl_pkg;

	localparam int OFF_W         = 26;
	localparam int REQ_W         = 16;
	localparam int CNT_W         = 11;
	localparam int CB_W          = 17;
	localparam int ST_W          = 3;
	localparam int CFG_W         = 16;
	localparam int CIDX_W        = 1;
	localparam int POINTER_BYTES = 8;

	localparam logic [REQ_W-1:0] REQ_RESET = 16'd64;
	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_ALIGN    = 3'd4,
		ST_OVERFREE = 3'd5
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_CHUNK_SIZE  = 1'b0,
		REG_CHUNK_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic div_start;
		logic cb_load;
		logic sweep_clr;
		logic sweep_wr;
		logic list_init;
		logic in_load;
		logic alloc_rd;
		logic alloc_commit;
		logic free_commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sweep_last;
	} dp_sts_t;

endpackage

// ===== rtl/core/fcfl_req_if.sv =====
// Request channel: allocate or free word, valid/ready handshake.
// Depends on fcfl_pkg.
interface fcfl_req_if;
	import fcfl_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [OFF_W-1:0] chunk_offset;
	logic             chunk_is_null;

	modport source (output valid, opcode, chunk_offset, chunk_is_null, input ready);
	modport sink   (input valid, opcode, chunk_offset, chunk_is_null, output ready);
endinterface

// ===== rtl/core/fcfl_rsp_if.sv =====
// Response channel: status, granted offset and free count, valid/ready handshake.
// Depends on fcfl_pkg.
interface fcfl_rsp_if;
	import fcfl_pkg::*;

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [OFF_W-1:0] granted_offset;
	logic [CNT_W-1:0] free_chunks;

	modport source (output valid, status, granted_offset, free_chunks, input ready);
	modport sink   (input valid, status, granted_offset, free_chunks, output ready);
endinterface

// ===== rtl/core/fcfl_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on fcfl_pkg.
module fcfl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fcfl_pkg::OFF_W-1:0] dividend,
	input  logic [fcfl_pkg::CB_W-1:0]  divisor,
	output logic                       done,
	output logic [fcfl_pkg::OFF_W-1:0] quotient,
	output logic [fcfl_pkg::CB_W-1:0]  remainder
);
	import fcfl_pkg::*;

	localparam int STEP_W = $clog2(OFF_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [OFF_W-1:0]  quo_q;
	logic [CB_W-1:0]   rem_q;
	logic [CB_W-1:0]   dsr_q;
	logic [CB_W:0]     trial;
	logic [CB_W:0]     diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[OFF_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(OFF_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[OFF_W-2:0], fits};
			rem_q <= fits ? diff[CB_W-1:0] : trial[CB_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== rtl/core/fcfl_dp.sv =====
// Datapath: configuration registers, link memory, head and free count, result register.
// Depends on fcfl_pkg and fcfl_div.
module fcfl_dp #(
	parameter int MAX_CHUNKS  = 1024,
	parameter int ALIGN_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcfl_pkg::dp_cmd_t           cmd,
	output fcfl_pkg::dp_sts_t           sts,
	input  logic                        cfg_we,
	input  logic [fcfl_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fcfl_pkg::CFG_W-1:0]  cfg_data,
	input  logic [fcfl_pkg::OFF_W-1:0]  in_offset,
	input  logic                        in_null,
	output logic [fcfl_pkg::ST_W-1:0]   status,
	output logic [fcfl_pkg::OFF_W-1:0]  granted_offset,
	output logic [fcfl_pkg::CNT_W-1:0]  free_chunks
);
	import fcfl_pkg::*;

	localparam int LW = $clog2(MAX_CHUNKS + 1);
	localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int PW = LW + CB_W;
	localparam logic [LW-1:0]   NO_NEXT    = LW'(MAX_CHUNKS);
	localparam logic [IW-1:0]   LAST_IDX   = IW'(MAX_CHUNKS - 1);
	localparam logic [CB_W-1:0] ALIGN_MASK = CB_W'(ALIGN_BYTES - 1);

	logic [REQ_W-1:0] req_q;
	logic [CNT_W-1:0] count_q;
	logic [CB_W-1:0]  cb_q;
	logic [LW-1:0]    head_q;
	logic [LW-1:0]    ft_q;
	logic [IW-1:0]    sweep_q;
	logic [OFF_W-1:0] off_q;
	logic             null_q;
	logic [LW-1:0]    rd_q;
	logic [PW-1:0]    prod_q;
	logic [LW-1:0]    link_mem [MAX_CHUNKS];
	status_t          status_q;
	logic [OFF_W-1:0] grant_q;
	logic [CNT_W-1:0] free_q;

	logic [LW-1:0]    n_used;
	logic [REQ_W-1:0] req_floor;
	logic [CB_W-1:0]  req_up;
	logic             div_done;
	logic [OFF_W-1:0] quo;
	logic [CB_W-1:0]  rem;
	logic [LW-1:0]    link_nxt;
	logic [LW-1:0]    link_init;
	logic             empty;
	logic             push;
	status_t          res_status;
	logic [OFF_W-1:0] res_grant;
	logic [LW-1:0]    ft_nxt;
	logic [LW-1:0]    head_nxt;

	// clamp the count to the pool capacity
	always_comb begin
		if (32'(count_q) > 32'(MAX_CHUNKS))
			n_used = NO_NEXT;
		else
			n_used = LW'(count_q);
		req_floor = (req_q < REQ_W'(POINTER_BYTES)) ? REQ_W'(POINTER_BYTES) : req_q;
		req_up    = CB_W'(req_floor) + CB_W'(ALIGN_BYTES - 1);
		link_nxt  = LW'(sweep_q) + LW'(1);
		link_init = (link_nxt < n_used) ? link_nxt : NO_NEXT;
	end

	fcfl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (off_q),
		.divisor   (cb_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_comb begin
		empty      = (head_q >= NO_NEXT) || (ft_q == '0);
		push       = 1'b0;
		res_status = ST_OK;
		res_grant  = '0;
		ft_nxt     = ft_q;
		head_nxt   = head_q;
		if (cmd.alloc_commit) begin
			if (empty) begin
				res_status = ST_EMPTY;
			end else begin
				res_grant = OFF_W'(prod_q);
				ft_nxt    = ft_q - LW'(1);
				head_nxt  = rd_q;
			end
		end else begin
			if (null_q)
				res_status = ST_NULL;
			else if (quo >= OFF_W'(n_used))
				res_status = ST_RANGE;
			else if (rem != '0)
				res_status = ST_ALIGN;
			else if (ft_q >= n_used)
				res_status = ST_OVERFREE;
			else begin
				push     = cmd.free_commit;
				ft_nxt   = ft_q + LW'(1);
				head_nxt = LW'(quo);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= REQ_RESET;
			count_q <= CNT_RESET;
			head_q  <= '0;
			ft_q    <= '0;
			sweep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_CHUNK_SIZE:  req_q   <= cfg_data[REQ_W-1:0];
					REG_CHUNK_COUNT: count_q <= cfg_data[CNT_W-1:0];
				endcase
			end
			if (cmd.sweep_clr)
				sweep_q <= '0;
			else if (cmd.sweep_wr)
				sweep_q <= sweep_q + IW'(1);
			if (cmd.list_init) begin
				head_q <= (n_used != '0) ? '0 : NO_NEXT;
				ft_q   <= n_used;
			end else if (cmd.alloc_commit || cmd.free_commit) begin
				head_q <= head_nxt;
				ft_q   <= ft_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cb_load)
			cb_q <= req_up & ~ALIGN_MASK;
		if (cmd.in_load) begin
			off_q  <= in_offset;
			null_q <= in_null;
		end
		if (cmd.alloc_rd)
			prod_q <= PW'(head_q) * PW'(cb_q);
		if (cmd.alloc_commit || cmd.free_commit) begin
			status_q <= res_status;
			grant_q  <= res_grant;
			free_q   <= CNT_W'(ft_nxt);
		end
	end

	// link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.sweep_wr)
			link_mem[sweep_q] <= link_init;
		else if (push)
			link_mem[quo[IW-1:0]] <= head_q;
		if (cmd.alloc_rd)
			rd_q <= link_mem[head_q[IW-1:0]];
	end

	assign sts.div_done   = div_done;
	assign sts.sweep_last = (sweep_q == LAST_IDX);

	assign status         = status_q;
	assign granted_offset = grant_q;
	assign free_chunks    = free_q;
endmodule

// ===== rtl/core/fcfl_ctrl.sv =====
// Controller: rebuild sequence, word acceptance and result handshake.
// Depends on fcfl_pkg and the assertion macro header.
`include "fixed_chunk_free_list_allocator_top_defines.svh"

module fcfl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              req_valid,
	input  logic              req_opcode,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fcfl_pkg::dp_cmd_t cmd,
	input  fcfl_pkg::dp_sts_t sts
);
	import fcfl_pkg::*;

	typedef enum logic [7:0] {
		S_CB_START   = 8'b00000001,
		S_SWEEP      = 8'b00000010,
		S_IDLE       = 8'b00000100,
		S_ALLOC_RD   = 8'b00001000,
		S_ALLOC_DONE = 8'b00010000,
		S_FREE_START = 8'b00100000,
		S_FREE_DIV   = 8'b01000000,
		S_FREE_CHK   = 8'b10000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		out_free  = !rsp_valid_q || rsp_ready;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CB_START: begin
				cmd.cb_load   = 1'b1;
				cmd.sweep_clr = 1'b1;
				state_d       = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					cmd.list_init = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.in_load = 1'b1;
					state_d = (opcode_t'(req_opcode) == OP_FREE) ? S_FREE_START : S_ALLOC_RD;
				end
			end
			S_ALLOC_RD: begin
				cmd.alloc_rd = 1'b1;
				state_d      = S_ALLOC_DONE;
			end
			S_ALLOC_DONE: begin
				if (out_free) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_FREE_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_FREE_DIV;
			end
			S_FREE_DIV: begin
				if (sts.div_done)
					state_d = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (out_free) begin
					cmd.free_commit = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_CB_START;
		endcase
		// restart the rebuild on any register write
		if (cfg_we)
			state_d = S_CB_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CB_START;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.alloc_commit || cmd.free_commit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	`FCFL_ASSERT_IMP(a_commit_room, (cmd.alloc_commit || cmd.free_commit), out_free, "result loaded over an untaken word")
	`FCFL_ASSERT_NXT(a_cfg_rebuild, cfg_we, (state_q == S_CB_START), "register write did not restart rebuild")
	`FCFL_ASSERT_NXT(a_div_clear, cmd.div_start, !sts.div_done, "divider done flag not cleared by start")
	`FCFL_ASSERT_IMP(a_chk_done, (state_q == S_FREE_CHK), sts.div_done, "free checked before quotient ready")
endmodule

// ===== rtl/core/fixed_chunk_free_list_allocator_top.sv =====
// Top level of the fixed-size chunk free-list allocator.
// Depends on fcfl_pkg, fcfl_req_if, fcfl_rsp_if, fcfl_ctrl and fcfl_dp.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode, chunk_offset, chunk_is_null
//   rsp      out  valid/ready    status, granted_offset, free_chunks
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// Allocate: link memory read and offset multiply in S_ALLOC_RD, result loaded in S_ALLOC_DONE.
// Free: the offset runs through the 26-step serial divider before the result is checked.
// Reset and every register write rebuild the list: S_CB_START sizes the chunk,
// then S_SWEEP writes the MAX_CHUNKS link entries, one entry a cycle; no word taken meanwhile.
// One word in work at a time; a new word is taken while the last result waits in the
// output register, and a finished result holds until that register is free.
module fixed_chunk_free_list_allocator_top #(
	parameter int MAX_CHUNKS  = 1024,
	parameter int ALIGN_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fcfl_req_if.sink                    req,
	fcfl_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [fcfl_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fcfl_pkg::CFG_W-1:0]  cfg_data
);
	import fcfl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	fcfl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	fcfl_dp #(
		.MAX_CHUNKS  (MAX_CHUNKS),
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_offset      (req.chunk_offset),
		.in_null        (req.chunk_is_null),
		.status         (rsp.status),
		.granted_offset (rsp.granted_offset),
		.free_chunks    (rsp.free_chunks)
	);
endmodule
